// File: hw/rtl/erms_pkg.sv
`timescale 1ns / 1ps

package erms_pkg;

    localparam int CmW    = 14;
    localparam int DigitW = 4;
    localparam int EchoW  = 16;
    localparam int MultW  = 8;
    localparam int DivW   = 8;
    localparam int StabW  = 3;
    localparam int ShowW  = 10;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    localparam logic [CmW-1:0]   CmMax   = 14'd16383;
    localparam logic [ShowW-1:0] ShowMax = 10'd999;

    localparam logic [MultW-1:0] MultReset = 8'd12;
    localparam logic [DivW-1:0]  DivReset  = 8'd58;
    localparam logic [StabW-1:0] StabReset = 3'd3;

    localparam logic [1:0] RegTickMultiplier = 2'd0;
    localparam logic [1:0] RegCmDivisor      = 2'd1;
    localparam logic [1:0] RegStableGroups   = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic update;
        logic hun;
        logic rem;
        logic ten;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/erms_if.sv
`timescale 1ns / 1ps

interface erms_in_if;
    logic                         valid;
    logic                         ready;
    logic [erms_pkg::EchoW-1:0]   echo_ticks;
    logic                         echo_seen;

    modport source (output valid, output echo_ticks, output echo_seen, input ready);
    modport sink   (input valid, input echo_ticks, input echo_seen, output ready);
endinterface

interface erms_out_if;
    logic                          valid;
    logic                          ready;
    logic [erms_pkg::CmW-1:0]      sample_cm;
    logic                          group_done;
    logic                          display_changed;
    logic [erms_pkg::DigitW-1:0]   hundreds_digit;
    logic [erms_pkg::DigitW-1:0]   tens_digit;
    logic [erms_pkg::DigitW-1:0]   ones_digit;

    modport source (output valid, output sample_cm, output group_done,
                    output display_changed, output hundreds_digit,
                    output tens_digit, output ones_digit, input ready);
    modport sink   (input valid, input sample_cm, input group_done,
                    input display_changed, input hundreds_digit,
                    input tens_digit, input ones_digit, output ready);
endinterface

// File: hw/rtl/echo_range_median_stabilizer.sv
`timescale 1ns / 1ps

// Channel     Dir  Handshake        Payload
// sample_in   in   valid/ready      echo_ticks[15:0], echo_seen
// result_out  out  valid/ready      sample_cm[13:0], group_done, display_changed,
//                                   hundreds_digit, tens_digit, ones_digit
// apb         in   psel/penable     paddr[3:0], pwdata, prdata (pready tied high)
//
// After a transaction is accepted, its result is built by one multiply, one quotient bit per
// cycle in the restoring divider, the median/update step, a decimal split into hundreds,
// remainder and tens, and the output load.
// The next transaction is accepted once the current result sits in the output
// register; a stalled output holds the block before its final load.
// Reset loads the register defaults and clears slot, shown value and count.

module echo_range_median_stabilizer
#(
    parameter int TICK_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    erms_in_if.sink                       sample_in,
    erms_out_if.source                    result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [erms_pkg::AddrW-1:0]    paddr,
    input  logic [erms_pkg::DataW-1:0]    pwdata,
    output logic [erms_pkg::DataW-1:0]    prdata,
    output logic                          pready
);

    logic [erms_pkg::MultW-1:0] mult_reg;
    logic [erms_pkg::DivW-1:0]  div_reg;
    logic [erms_pkg::StabW-1:0] stab_reg;
    logic                       wr_en;
    logic [1:0]                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= erms_pkg::MultReset;
            div_reg  <= erms_pkg::DivReset;
            stab_reg <= erms_pkg::StabReset;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                erms_pkg::RegTickMultiplier: mult_reg <= pwdata[erms_pkg::MultW-1:0];
                erms_pkg::RegCmDivisor:      div_reg  <= pwdata[erms_pkg::DivW-1:0];
                erms_pkg::RegStableGroups:   stab_reg <= pwdata[erms_pkg::StabW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            erms_pkg::RegTickMultiplier: prdata = erms_pkg::DataW'(mult_reg);
            erms_pkg::RegCmDivisor:      prdata = erms_pkg::DataW'(div_reg);
            erms_pkg::RegStableGroups:   prdata = erms_pkg::DataW'(stab_reg);
            default:                     prdata = '0;
        endcase
    end

    erms_pkg::cmd_t cmd;
    erms_pkg::sts_t sts;

    erms_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    erms_dp
    #(
        .TICK_BITS (TICK_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .echo_ticks      (sample_in.echo_ticks),
        .echo_seen       (sample_in.echo_seen),
        .tick_multiplier (mult_reg),
        .cm_divisor      (div_reg),
        .stable_groups   (stab_reg),
        .result_out      (result_out)
    );

endmodule

// File: hw/rtl/erms_ctrl.sv
`timescale 1ns / 1ps

module erms_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  erms_pkg::sts_t  sts,
    output erms_pkg::cmd_t  cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul  = 3'd1;
    localparam logic [2:0] StDiv  = 3'd2;
    localparam logic [2:0] StUpd  = 3'd3;
    localparam logic [2:0] StHun  = 3'd4;
    localparam logic [2:0] StRem  = 3'd5;
    localparam logic [2:0] StTen  = 3'd6;
    localparam logic [2:0] StDone = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            StIdle:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = StMul;
                end
            end
            StMul:
            begin
                cmd.mul    = 1'b1;
                state_next = StDiv;
            end
            StDiv:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = StUpd;
                end
            end
            StUpd:
            begin
                cmd.update = 1'b1;
                state_next = StHun;
            end
            StHun:
            begin
                cmd.hun    = 1'b1;
                state_next = StRem;
            end
            StRem:
            begin
                cmd.rem    = 1'b1;
                state_next = StTen;
            end
            StTen:
            begin
                cmd.ten    = 1'b1;
                state_next = StDone;
            end
            StDone:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/erms_dp.sv
`timescale 1ns / 1ps

module erms_dp
#(
    parameter int TICK_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  erms_pkg::cmd_t                  cmd,
    output erms_pkg::sts_t                  sts,
    input  logic [erms_pkg::EchoW-1:0]      echo_ticks,
    input  logic                            echo_seen,
    input  logic [erms_pkg::MultW-1:0]      tick_multiplier,
    input  logic [erms_pkg::DivW-1:0]       cm_divisor,
    input  logic [erms_pkg::StabW-1:0]      stable_groups,
    erms_out_if.source                      result_out
);

    localparam int ProdW = TICK_BITS + erms_pkg::MultW;
    localparam int CntW  = $clog2(ProdW);
    localparam int CmW   = erms_pkg::CmW;

    localparam logic [CntW-1:0] CntLast = CntW'(ProdW - 1);

    logic [TICK_BITS-1:0] tick_in;

    generate
        if (TICK_BITS > erms_pkg::EchoW)
        begin : g_ext
            assign tick_in = {{(TICK_BITS - erms_pkg::EchoW){1'b0}}, echo_ticks};
        end
        else if (TICK_BITS == erms_pkg::EchoW)
        begin : g_same
            assign tick_in = echo_ticks;
        end
        else
        begin : g_cut
            assign tick_in = echo_ticks[TICK_BITS-1:0];
        end
    endgenerate

    logic [TICK_BITS-1:0]         ticks_reg;
    logic                         seen_reg;
    logic [ProdW-1:0]             quo_reg;
    logic [erms_pkg::DivW-1:0]    rem_reg;
    logic [CntW-1:0]              cnt_reg;
    logic [CmW-1:0]               store_reg [3];
    logic [1:0]                   slot_reg;
    logic [CmW-1:0]               shown_reg;
    logic [erms_pkg::StabW-1:0]   change_reg;
    logic [CmW-1:0]               cm_reg;
    logic                         done_reg;
    logic                         changed_reg;
    logic [erms_pkg::DigitW-1:0]  hun_reg;
    logic [6:0]                   rem100_reg;
    logic [erms_pkg::DigitW-1:0]  ten_reg;

    logic                         out_valid_reg;
    logic [CmW-1:0]               out_cm_reg;
    logic                         out_done_reg;
    logic                         out_changed_reg;
    logic [erms_pkg::DigitW-1:0]  out_hun_reg;
    logic [erms_pkg::DigitW-1:0]  out_ten_reg;
    logic [erms_pkg::DigitW-1:0]  out_one_reg;

    // restoring divide step
    logic [erms_pkg::DivW:0]      trial;
    logic                         trial_ge;
    logic [erms_pkg::DivW:0]      trial_sub;

    assign trial     = {rem_reg, quo_reg[ProdW-1]};
    assign trial_ge  = trial >= {1'b0, cm_divisor};
    assign trial_sub = trial - {1'b0, cm_divisor};

    logic [CmW-1:0] quo_sat;
    logic [CmW-1:0] cm_val;

    assign quo_sat = (|quo_reg[ProdW-1:CmW]) ? erms_pkg::CmMax : quo_reg[CmW-1:0];
    assign cm_val  = seen_reg ? quo_sat : '0;

    // median of the two stored values and the new one
    logic [CmW-1:0] lo_ab;
    logic [CmW-1:0] hi_ab;
    logic [CmW-1:0] mid_c;
    logic [CmW-1:0] med;

    assign lo_ab = (store_reg[0] < store_reg[1]) ? store_reg[0] : store_reg[1];
    assign hi_ab = (store_reg[0] < store_reg[1]) ? store_reg[1] : store_reg[0];
    assign mid_c = (hi_ab < cm_val) ? hi_ab : cm_val;
    assign med   = (lo_ab > mid_c) ? lo_ab : mid_c;

    logic [erms_pkg::StabW-1:0] need;
    logic [erms_pkg::StabW-1:0] change_inc;

    assign need       = (stable_groups == '0) ? erms_pkg::StabW'(1) : stable_groups;
    assign change_inc = (change_reg == '1) ? change_reg : change_reg + 1'b1;

    // decimal split: x/100 ~ x*41>>12 for x<1000, r/10 ~ r*205>>11 for r<100
    logic [erms_pkg::ShowW-1:0] show_v;
    logic [15:0]                hun_prod;
    logic [erms_pkg::ShowW-1:0] rem_full;
    logic [14:0]                ten_prod;
    logic [6:0]                 one_full;

    assign show_v   = (shown_reg > CmW'(erms_pkg::ShowMax)) ? erms_pkg::ShowMax
                                                            : shown_reg[erms_pkg::ShowW-1:0];
    assign hun_prod = 16'(show_v) * 16'd41;
    assign rem_full = show_v - erms_pkg::ShowW'(hun_reg) * erms_pkg::ShowW'(100);
    assign ten_prod = 15'(rem100_reg) * 15'd205;
    assign one_full = rem100_reg - 7'(ten_reg) * 7'd10;

    assign sts.div_last = (cnt_reg == CntLast);
    assign sts.out_free = !out_valid_reg || result_out.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ticks_reg <= tick_in;
            seen_reg  <= echo_seen;
        end
        if (cmd.mul)
        begin
            quo_reg <= ProdW'(ticks_reg) * ProdW'(tick_multiplier);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[ProdW-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[erms_pkg::DivW-1:0] : trial[erms_pkg::DivW-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.update)
        begin
            cm_reg              <= cm_val;
            store_reg[slot_reg] <= cm_val;
        end
        if (cmd.hun)
        begin
            hun_reg <= hun_prod[15:12];
        end
        if (cmd.rem)
        begin
            rem100_reg <= rem_full[6:0];
        end
        if (cmd.ten)
        begin
            ten_reg <= ten_prod[14:11];
        end
        if (cmd.emit)
        begin
            out_cm_reg      <= cm_reg;
            out_done_reg    <= done_reg;
            out_changed_reg <= changed_reg;
            out_hun_reg     <= hun_reg;
            out_ten_reg     <= ten_reg;
            out_one_reg     <= one_full[erms_pkg::DigitW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            shown_reg     <= '0;
            change_reg    <= '0;
            done_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                done_reg    <= 1'b0;
                changed_reg <= 1'b0;
                if (slot_reg == 2'd2)
                begin
                    slot_reg <= '0;
                    done_reg <= 1'b1;
                    if (med == shown_reg)
                    begin
                        change_reg <= '0;
                    end
                    else if (change_inc >= need)
                    begin
                        change_reg  <= '0;
                        shown_reg   <= med;
                        changed_reg <= 1'b1;
                    end
                    else
                    begin
                        change_reg <= change_inc;
                    end
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.sample_cm       = out_cm_reg;
    assign result_out.group_done      = out_done_reg;
    assign result_out.display_changed = out_changed_reg;
    assign result_out.hundreds_digit  = out_hun_reg;
    assign result_out.tens_digit      = out_ten_reg;
    assign result_out.ones_digit      = out_one_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import erms_pkg::*;

    localparam int ClkPeriod  = 20;
    localparam int StallLimit = 3000;
    localparam int LongHold   = 400;
    localparam int PhaseItems = 160;
    localparam int NumPhases  = 8;

    typedef struct packed {
        logic [CmW-1:0]    sample_cm;
        logic              group_done;
        logic              display_changed;
        logic [DigitW-1:0] hundreds_digit;
        logic [DigitW-1:0] tens_digit;
        logic [DigitW-1:0] ones_digit;
    } echo_result_t;

    class range_scoreboard;
        logic [MultW-1:0] tick_mult;
        logic [DivW-1:0]  cm_div;
        logic [StabW-1:0] stable_need;
        logic [CmW-1:0]   window [3];
        int unsigned      slot;
        logic [CmW-1:0]   shown;
        int unsigned      diff_run;
        echo_result_t     expected_q [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      groups;
        int unsigned      updates;

        function new();
            tick_mult   = MultReset;
            cm_div      = DivReset;
            stable_need = StabReset;
            foreach (window[i])
                window[i] = '0;
            slot     = 0;
            shown    = '0;
            diff_run = 0;
            errors   = 0;
            checked  = 0;
            groups   = 0;
            updates  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DataW-1:0] val);
            case (idx)
                RegTickMultiplier: tick_mult   = val[MultW-1:0];
                RegCmDivisor:      cm_div      = val[DivW-1:0];
                RegStableGroups:   stable_need = val[StabW-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [EchoW-1:0] ticks, logic seen);
            logic [63:0]    quot;
            logic [CmW-1:0] cm;
            logic [CmW-1:0] lo;
            logic [CmW-1:0] hi;
            logic [CmW-1:0] med;
            int unsigned    need;
            int unsigned    show;
            echo_result_t   r;

            if (!seen)
                cm = '0;
            else if (cm_div == 0)
                cm = CmMax;
            else
            begin
                quot = (64'(ticks) * 64'(tick_mult)) / 64'(cm_div);
                cm   = (quot > 64'(CmMax)) ? CmMax : quot[CmW-1:0];
            end

            r = '0;
            r.sample_cm = cm;
            window[slot] = cm;
            slot++;
            if (slot == 3)
            begin
                slot = 0;
                r.group_done = 1'b1;
                lo  = (window[0] < window[1]) ? window[0] : window[1];
                hi  = (window[0] < window[1]) ? window[1] : window[0];
                med = (hi < window[2]) ? hi : window[2];
                if (lo > med)
                    med = lo;
                need = (stable_need == 0) ? 1 : 32'(stable_need);
                if (med == shown)
                    diff_run = 0;
                else
                begin
                    if (diff_run < 7)
                        diff_run++;
                    if (diff_run >= need)
                    begin
                        diff_run = 0;
                        shown = med;
                        r.display_changed = 1'b1;
                    end
                end
            end

            show = (shown > 14'(ShowMax)) ? 32'(ShowMax) : 32'(shown);
            r.hundreds_digit = DigitW'(show / 100);
            r.tens_digit     = DigitW'((show % 100) / 10);
            r.ones_digit     = DigitW'(show % 10);
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(echo_result_t got);
            echo_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.group_done)
                groups++;
            if (want.display_changed)
                updates++;
            check_field("sample_cm", 32'(want.sample_cm), 32'(got.sample_cm));
            check_field("group_done", 32'(want.group_done), 32'(got.group_done));
            check_field("display_changed", 32'(want.display_changed),
                        32'(got.display_changed));
            check_field("hundreds_digit", 32'(want.hundreds_digit), 32'(got.hundreds_digit));
            check_field("tens_digit", 32'(want.tens_digit), 32'(got.tens_digit));
            check_field("ones_digit", 32'(want.ones_digit), 32'(got.ones_digit));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    erms_in_if  sample_if ();
    erms_out_if result_if ();

    range_scoreboard sb;
    bit              tx_gaps   = 1'b1;
    bit              rx_gaps   = 1'b1;
    bit              hold_long = 1'b0;
    int unsigned     settings  = 0;
    int unsigned     stall_cycles;

    echo_range_median_stabilizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_if),
        .result_out (result_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && sample_if.valid && sample_if.ready)
            sb.note_sample(sample_if.echo_ticks, sample_if.echo_seen);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_result({result_if.sample_cm, result_if.group_done,
                             result_if.display_changed, result_if.hundreds_digit,
                             result_if.tens_digit, result_if.ones_digit});
    end

    // output backpressure: random bursts, or one long hold on request
    initial
    begin
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                result_if.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                hold_long = 1'b0;
                result_if.ready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_if.ready <= 1'b1;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) ||
                (result_if.valid && result_if.ready) || psel)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding",
                 StallLimit, sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_sample(input logic [EchoW-1:0] ticks, input logic seen);
        sample_if.valid      <= 1'b1;
        sample_if.echo_ticks <= ticks;
        sample_if.echo_seen  <= seen;
        do
            @(posedge clk);
        while (!sample_if.ready);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input int mult, input int div, input int stab);
        drain();
        write_reg(RegTickMultiplier, DataW'(mult));
        write_reg(RegCmDivisor, DataW'(div));
        write_reg(RegStableGroups, DataW'(stab));
        settings++;
    endtask

    task automatic run_stream(input int count, input bit quiet);
        int          left;
        int          seg;
        int          mode;
        int unsigned base;
        logic [EchoW-1:0] ticks;
        logic             seen;

        left = count;
        while (left > 0)
        begin
            mode    = $urandom_range(0, 4);
            seg     = 3 * $urandom_range(1, 8);
            base    = $urandom_range(0, 8000);
            tx_gaps = !quiet && ($urandom_range(0, 2) != 0);
            rx_gaps = !quiet && ($urandom_range(0, 2) != 0);
            for (int i = 0; i < seg; i++)
            begin
                case (mode)
                    0:
                    begin
                        ticks = EchoW'(base + $urandom_range(0, 2));
                        seen  = ($urandom_range(0, 15) != 0);
                    end
                    1:
                    begin
                        ticks = EchoW'($urandom);
                        seen  = 1'($urandom);
                    end
                    2:
                    begin
                        ticks = EchoW'($urandom_range(0, 600));
                        seen  = 1'b1;
                    end
                    3:
                    begin
                        ticks = EchoW'($urandom);
                        seen  = 1'b0;
                    end
                    default:
                    begin
                        ticks = EchoW'($urandom_range(4000, 65535));
                        seen  = 1'b1;
                    end
                endcase
                send_sample(ticks, seen);
            end
            left -= seg;
            if (!quiet && $urandom_range(0, 9) == 0)
                drain();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        sample_if.valid      <= 1'b0;
        sample_if.echo_ticks <= '0;
        sample_if.echo_seen  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: range extremes, no echo, display saturation
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd0, 1'b0);
        for (int i = 0; i < 9; i++)
            send_sample(16'd5000, 1'b1);

        // product saturation, single-group update
        configure(255, 1, 1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'd1, 1'b1);
        send_sample(16'd64, 1'b1);
        for (int i = 0; i < 3; i++)
            send_sample(16'd0, 1'b1);

        // zero divisor and zero stable count
        configure(12, 0, 0);
        send_sample(16'd123, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b0);

        for (int p = 0; p < NumPhases; p++)
        begin
            case (p)
                0: configure(12, 58, 3);
                1: configure(255, 1, 1);
                3: configure(1, 255, 7);
                4: configure(200, 0, 0);
                5: configure(0, $urandom_range(1, 255), 2);
                default: configure($urandom_range(1, 255), $urandom_range(1, 255),
                                   $urandom_range(1, 7));
            endcase
            if (p == 2)
            begin
                // output held off while input keeps coming
                tx_gaps   = 1'b0;
                hold_long = 1'b1;
                for (int i = 0; i < 24; i++)
                    send_sample(EchoW'($urandom_range(0, 3000)), 1'b1);
            end
            run_stream(PhaseItems, p == NumPhases - 1);
        end

        drain();
        repeat (40) @(posedge clk);
        $display("%0d echo transactions checked under %0d register settings", sb.checked,
                 settings + 1);
        $display("%0d median groups completed, %0d display updates", sb.groups, sb.updates);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
